### rtl/cwct_pkg.sv
// Shared types and constants of the colour window centroid tracker.
package cwct_pkg;

    localparam int unsigned PIX_W     = 8;
    localparam int unsigned COORD_W   = 12;
    localparam int unsigned HALF_W    = COORD_W - 1;
    localparam int unsigned SUM_W     = 36;
    localparam int unsigned CNT_W     = 24;
    localparam int unsigned STEP_W    = 6;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 12;

    localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_REF_RED      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_GREEN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REF_BLUE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOL_RED      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOL_GREEN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOL_BLUE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd7;

    typedef struct packed {
        logic [PIX_W-1:0]   ref_red;
        logic [PIX_W-1:0]   ref_green;
        logic [PIX_W-1:0]   ref_blue;
        logic [PIX_W-1:0]   tol_red;
        logic [PIX_W-1:0]   tol_green;
        logic [PIX_W-1:0]   tol_blue;
        logic [COORD_W-1:0] frame_width;
        logic [COORD_W-1:0] frame_height;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] xmin;
        logic [COORD_W-1:0] xmax;
        logic [COORD_W-1:0] ymin;
        logic [COORD_W-1:0] ymax;
        logic [COORD_W-1:0] sxmin;
        logic [COORD_W-1:0] sxmax;
        logic [COORD_W-1:0] symin;
        logic [COORD_W-1:0] symax;
        logic [COORD_W-1:0] half_w;
        logic [COORD_W-1:0] half_h;
    } t_bounds;

    typedef struct packed {
        logic               hit;
        logic [COORD_W-1:0] col_off;
        logic [COORD_W-1:0] row_off;
        logic               last;
    } t_pix_item;

    typedef struct packed {
        logic zoomed;
        logic frame_end;
    } t_back_status;

endpackage

### rtl/color_window_centroid_tracker.sv
// Top level of the colour window centroid tracker: register file and block wiring.
//
//   channel   direction   handshake              payload
//   pixel     in          i_in_valid/o_in_stall  i_blue i_green i_red i_col i_row i_frame_last
//   result    out         o_out_valid/i_out_stall o_hit o_frame_done o_centroid_x/y o_visible
//   config    in          i_cfg_valid/o_cfg_ready i_cfg_index i_cfg_data
//
// One pixel transfer per cycle is sustained while the result is not stalled.
// The frame's last pixel occupies the back end while the one-bit-per-cycle
// restoring divider works over the 36-bit sums, and new pixels are held off
// until the window for the next frame is known.
// After reset, and after any register write, input is stalled until the bounds settle.
// A stalled result holds its value; the two-entry queue lets the front end keep
// accepting pixels while the result register waits.
module color_window_centroid_tracker import cwct_pkg::*; #(
    parameter int unsigned ZOOM_FACTOR = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [PIX_W-1:0]     i_blue,
    input  logic [PIX_W-1:0]     i_green,
    input  logic [PIX_W-1:0]     i_red,
    input  logic [COORD_W-1:0]   i_col,
    input  logic [COORD_W-1:0]   i_row,
    input  logic                 i_frame_last,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_hit,
    output logic                 o_frame_done,
    output logic [COORD_W-1:0]   o_centroid_x,
    output logic [COORD_W-1:0]   o_centroid_y,
    output logic                 o_visible,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg         r_cfg, n_cfg;
    logic         cfg_we;
    t_back_status status;
    t_bounds      bnd;
    t_pix_item    push_item, head_item;
    logic         push, pop, q_full, q_valid;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_we) begin
            unique case (i_cfg_index)
                REG_REF_RED:      n_cfg.ref_red      = i_cfg_data[PIX_W-1:0];
                REG_REF_GREEN:    n_cfg.ref_green    = i_cfg_data[PIX_W-1:0];
                REG_REF_BLUE:     n_cfg.ref_blue     = i_cfg_data[PIX_W-1:0];
                REG_TOL_RED:      n_cfg.tol_red      = i_cfg_data[PIX_W-1:0];
                REG_TOL_GREEN:    n_cfg.tol_green    = i_cfg_data[PIX_W-1:0];
                REG_TOL_BLUE:     n_cfg.tol_blue     = i_cfg_data[PIX_W-1:0];
                REG_FRAME_WIDTH:  n_cfg.frame_width  = i_cfg_data[COORD_W-1:0];
                REG_FRAME_HEIGHT: n_cfg.frame_height = i_cfg_data[COORD_W-1:0];
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ref_red      <= 8'd0;
            r_cfg.ref_green    <= 8'd255;
            r_cfg.ref_blue     <= 8'd0;
            r_cfg.tol_red      <= 8'd20;
            r_cfg.tol_green    <= 8'd20;
            r_cfg.tol_blue     <= 8'd20;
            r_cfg.frame_width  <= 12'd640;
            r_cfg.frame_height <= 12'd480;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    cwct_front #(
        .ZOOM_FACTOR(ZOOM_FACTOR)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cfg_we     (cfg_we),
        .i_status     (status),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_blue       (i_blue),
        .i_green      (i_green),
        .i_red        (i_red),
        .i_col        (i_col),
        .i_row        (i_row),
        .i_frame_last (i_frame_last),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_item       (push_item),
        .o_bnd        (bnd)
    );

    cwct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    cwct_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_item     (head_item),
        .o_pop        (pop),
        .i_bnd        (bnd),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hit        (o_hit),
        .o_frame_done (o_frame_done),
        .o_centroid_x (o_centroid_x),
        .o_centroid_y (o_centroid_y),
        .o_visible    (o_visible)
    );

endmodule

### rtl/cwct_front.sv
// Front end: search window bounds, pixel classification and transfer into the queue.
module cwct_front import cwct_pkg::*; #(
    parameter int unsigned ZOOM_FACTOR = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_cfg_we,
    input  t_back_status       i_status,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [PIX_W-1:0]   i_blue,
    input  logic [PIX_W-1:0]   i_green,
    input  logic [PIX_W-1:0]   i_red,
    input  logic [COORD_W-1:0] i_col,
    input  logic [COORD_W-1:0] i_row,
    input  logic               i_frame_last,
    input  logic               i_q_full,
    output logic               o_push,
    output t_pix_item          o_item,
    output t_bounds            o_bnd
);

    localparam int unsigned ZSH      = 24;
    localparam int unsigned ZRECIP_I = ((1 << ZSH) + ZOOM_FACTOR - 1) / ZOOM_FACTOR;
    localparam int unsigned PROD_W   = HALF_W + ZSH + 1;
    localparam logic [PROD_W-1:0] ZRECIP = PROD_W'(ZRECIP_I);

    function automatic logic near_ref(input logic [PIX_W-1:0] pix,
                                      input logic [PIX_W-1:0] refv,
                                      input logic [PIX_W-1:0] tol);
        logic [PIX_W:0] p_up;
        logic [PIX_W:0] r_up;
        p_up = {1'b0, pix} + {1'b0, tol};
        r_up = {1'b0, refv} + {1'b0, tol};
        return (p_up >= {1'b0, refv}) && ({1'b0, pix} <= r_up);
    endfunction

    logic [HALF_W-1:0] half_w;
    logic [HALF_W-1:0] half_h;
    logic [PROD_W-1:0] prod_w;
    logic [PROD_W-1:0] prod_h;
    logic [HALF_W-1:0] r_hw, r_hh, r_qw, r_qh;
    t_bounds           r_bnd, n_bnd;
    logic [1:0]        r_settle, n_settle;
    logic              r_wait, n_wait;
    logic              accept;
    logic              in_win;
    logic              colour_ok;

    assign half_w = i_cfg.frame_width[COORD_W-1:1];
    assign half_h = i_cfg.frame_height[COORD_W-1:1];
    assign prod_w = PROD_W'(half_w) * ZRECIP;
    assign prod_h = PROD_W'(half_h) * ZRECIP;

    always_ff @(posedge i_clk) begin
        r_hw  <= half_w;
        r_hh  <= half_h;
        r_qw  <= prod_w[ZSH +: HALF_W];
        r_qh  <= prod_h[ZSH +: HALF_W];
        r_bnd <= n_bnd;
    end

    always_comb begin
        n_bnd.sxmin  = {1'b0, r_hw - r_qw};
        n_bnd.sxmax  = {1'b0, r_hw} + {1'b0, r_qw};
        n_bnd.symin  = {1'b0, r_hh - r_qh};
        n_bnd.symax  = {1'b0, r_hh} + {1'b0, r_qh};
        n_bnd.half_w = {1'b0, r_hw};
        n_bnd.half_h = {1'b0, r_hh};
        if (i_status.zoomed) begin
            n_bnd.xmin = n_bnd.sxmin;
            n_bnd.xmax = n_bnd.sxmax;
            n_bnd.ymin = n_bnd.symin;
            n_bnd.ymax = n_bnd.symax;
        end else begin
            n_bnd.xmin = '0;
            n_bnd.xmax = {r_hw, 1'b0};
            n_bnd.ymin = '0;
            n_bnd.ymax = {r_hh, 1'b0};
        end
    end

    assign o_in_stall = r_wait || (r_settle != 2'd0) || i_q_full;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_settle = r_settle;
        if (i_cfg_we || i_status.frame_end) begin
            n_settle = 2'd2;
        end else if (r_settle != 2'd0) begin
            n_settle = r_settle - 2'd1;
        end
        n_wait = r_wait;
        if (i_status.frame_end) begin
            n_wait = 1'b0;
        end else if (accept && i_frame_last) begin
            n_wait = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= 2'd2;
            r_wait   <= 1'b0;
        end else begin
            r_settle <= n_settle;
            r_wait   <= n_wait;
        end
    end

    assign in_win = (i_col >= r_bnd.xmin) && (i_col < r_bnd.xmax) &&
                    (i_row >= r_bnd.ymin) && (i_row < r_bnd.ymax);
    assign colour_ok = near_ref(i_blue, i_cfg.ref_blue, i_cfg.tol_blue) &&
                       near_ref(i_green, i_cfg.ref_green, i_cfg.tol_green) &&
                       near_ref(i_red, i_cfg.ref_red, i_cfg.tol_red);

    assign o_push         = accept;
    assign o_item.hit     = in_win && colour_ok;
    assign o_item.col_off = i_col - r_bnd.xmin;
    assign o_item.row_off = i_row - r_bnd.ymin;
    assign o_item.last    = i_frame_last;
    assign o_bnd          = r_bnd;

endmodule

### rtl/cwct_queue.sv
// Short queue of classified pixels between the front end and the back end.
module cwct_queue import cwct_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_pix_item i_item,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_valid,
    output t_pix_item o_item
);

    t_pix_item         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/cwct_back.sv
// Back end: accumulation, centroid division, window update and the result register.
module cwct_back import cwct_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_pix_item          i_q_item,
    output logic               o_pop,
    input  t_bounds            i_bnd,
    output t_back_status       o_status,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_hit,
    output logic               o_frame_done,
    output logic [COORD_W-1:0] o_centroid_x,
    output logic [COORD_W-1:0] o_centroid_y,
    output logic               o_visible
);

    localparam logic [1:0] ST_RUN = 2'd0;
    localparam logic [1:0] ST_DIV = 2'd1;
    localparam logic [1:0] ST_FIN = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [SUM_W-1:0]   r_sx, n_sx, r_sy, n_sy;
    logic [SUM_W-1:0]   r_dvd_x, n_dvd_x, r_dvd_y, n_dvd_y;
    logic [CNT_W-1:0]   r_rem_x, n_rem_x, r_rem_y, n_rem_y;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_zoomed, n_zoomed;
    logic               r_last_hit, n_last_hit;
    logic               r_out_valid, n_out_valid;
    logic               r_hit, n_hit, r_done, n_done, r_vis, n_vis;
    logic [COORD_W-1:0] r_cx, n_cx, r_cy, n_cy;
    logic               out_free;
    logic               acc;
    logic [CNT_W-1:0]   acc_cnt;
    logic [SUM_W-1:0]   acc_sx, acc_sy;
    logic [CNT_W:0]     trial_x, trial_y;
    logic               ge_x, ge_y;
    logic [COORD_W-1:0] cx, cy;
    logic               vis, zoom_in;

    assign out_free = !r_out_valid || !i_out_stall;

    assign acc     = i_q_item.hit && (r_cnt != COUNT_MAX);
    assign acc_cnt = acc ? r_cnt + 1'b1 : r_cnt;
    assign acc_sx  = acc ? r_sx + SUM_W'(i_q_item.col_off) : r_sx;
    assign acc_sy  = acc ? r_sy + SUM_W'(i_q_item.row_off) : r_sy;

    assign trial_x = {r_rem_x, r_dvd_x[SUM_W-1]};
    assign trial_y = {r_rem_y, r_dvd_y[SUM_W-1]};
    assign ge_x    = trial_x >= {1'b0, r_cnt};
    assign ge_y    = trial_y >= {1'b0, r_cnt};

    assign vis     = (r_cnt != '0);
    assign cx      = vis ? i_bnd.xmin + r_dvd_x[COORD_W-1:0] : i_bnd.half_w;
    assign cy      = vis ? i_bnd.ymin + r_dvd_y[COORD_W-1:0] : i_bnd.half_h;
    assign zoom_in = (cx > i_bnd.sxmin) && (cx < i_bnd.sxmax) &&
                     (cy > i_bnd.symin) && (cy < i_bnd.symax);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_dvd_x     = r_dvd_x;
        n_dvd_y     = r_dvd_y;
        n_rem_x     = r_rem_x;
        n_rem_y     = r_rem_y;
        n_step      = r_step;
        n_zoomed    = r_zoomed;
        n_last_hit  = r_last_hit;
        n_out_valid = r_out_valid && i_out_stall;
        n_hit       = r_hit;
        n_done      = r_done;
        n_vis       = r_vis;
        n_cx        = r_cx;
        n_cy        = r_cy;
        o_pop       = 1'b0;
        o_status.zoomed    = r_zoomed;
        o_status.frame_end = 1'b0;
        unique case (r_state)
            ST_RUN: begin
                if (i_q_valid && out_free) begin
                    o_pop = 1'b1;
                    n_cnt = acc_cnt;
                    n_sx  = acc_sx;
                    n_sy  = acc_sy;
                    if (i_q_item.last) begin
                        n_dvd_x    = acc_sx;
                        n_dvd_y    = acc_sy;
                        n_rem_x    = '0;
                        n_rem_y    = '0;
                        n_step     = '0;
                        n_last_hit = i_q_item.hit;
                        n_state    = ST_DIV;
                    end else begin
                        n_out_valid = 1'b1;
                        n_hit       = i_q_item.hit;
                        n_done      = 1'b0;
                        n_vis       = 1'b0;
                        n_cx        = '0;
                        n_cy        = '0;
                    end
                end
            end
            ST_DIV: begin
                n_rem_x = ge_x ? CNT_W'(trial_x - {1'b0, r_cnt}) : CNT_W'(trial_x);
                n_rem_y = ge_y ? CNT_W'(trial_y - {1'b0, r_cnt}) : CNT_W'(trial_y);
                n_dvd_x = {r_dvd_x[SUM_W-2:0], ge_x};
                n_dvd_y = {r_dvd_y[SUM_W-2:0], ge_y};
                n_step  = r_step + 1'b1;
                if (r_step == DIV_LAST) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_hit       = r_last_hit;
                    n_done      = 1'b1;
                    n_vis       = vis;
                    n_cx        = cx;
                    n_cy        = cy;
                    n_zoomed    = vis ? (zoom_in || r_zoomed) : 1'b0;
                    n_cnt       = '0;
                    n_sx        = '0;
                    n_sy        = '0;
                    n_state     = ST_RUN;
                    o_status.frame_end = 1'b1;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_cnt       <= '0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_zoomed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_sx        <= n_sx;
            r_sy        <= n_sy;
            r_zoomed    <= n_zoomed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd_x    <= n_dvd_x;
        r_dvd_y    <= n_dvd_y;
        r_rem_x    <= n_rem_x;
        r_rem_y    <= n_rem_y;
        r_step     <= n_step;
        r_last_hit <= n_last_hit;
        r_hit      <= n_hit;
        r_done     <= n_done;
        r_vis      <= n_vis;
        r_cx       <= n_cx;
        r_cy       <= n_cy;
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_hit;
    assign o_frame_done = r_done;
    assign o_centroid_x = r_cx;
    assign o_centroid_y = r_cy;
    assign o_visible    = r_vis;

endmodule

### rtl/cwct_checker.sv
// Port-level checks of the colour window centroid tracker and their binding.
module cwct_checker import cwct_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               i_frame_last,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic               o_hit,
    input logic               o_frame_done,
    input logic [COORD_W-1:0] o_centroid_x,
    input logic [COORD_W-1:0] o_centroid_y,
    input logic               o_visible
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_hit) &&
        $stable(o_frame_done) && $stable(o_centroid_x) &&
        $stable(o_centroid_y) && $stable(o_visible))
        else $error("stalled result changed");

    a_plain_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_frame_done |->
        o_centroid_x == '0 && o_centroid_y == '0 && !o_visible)
        else $error("centroid fields set on an ordinary pixel result");

    a_vis_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_visible |-> o_frame_done)
        else $error("visible without frame completion");

    a_last_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_frame_last |=> o_in_stall)
        else $error("pixel taken before the frame result was finished");

endmodule

bind color_window_centroid_tracker cwct_checker u_cwct_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_frame_last (i_frame_last),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_hit        (o_hit),
    .o_frame_done (o_frame_done),
    .o_centroid_x (o_centroid_x),
    .o_centroid_y (o_centroid_y),
    .o_visible    (o_visible)
);
